// ----- src/lsmm_pkg.sv -----
// ----------------------------------------------------------------------------
// lsmm_pkg: shared definitions for the small matrix multiply-add block
// Table geometry, request codes, controller states, command and status
// structures, and the mask helper for the power-of-two modulus.
// ----------------------------------------------------------------------------
package lsmm_pkg;

    // Table geometry and field widths.
    localparam int NBAR      = 8;
    localparam int IDX_W     = 3;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = NBAR * NBAR;
    localparam int VAL_W     = 16;
    localparam int LOGQ_W    = 5;
    localparam int REQ_W     = 2;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Request codes carried on s_tuser.
    localparam logic [REQ_W-1:0] REQ_INIT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MAC  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    // Register map.
    localparam logic [PADDR_W-3:0] REG_LOG_MODULUS = 1'b0;
    localparam logic [LOGQ_W-1:0]  LOGQ_RESET      = 5'd15;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // take a request, start the table read and the multiply
        logic commit;   // finish the held request: table write or result load
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [REQ_W-1:0] req_type;  // kind of the held request
        logic             out_free;  // output register can take a result now
    } sts_t;

    // Mask of the low log_modulus bits; sizes above the word act as the word.
    function automatic logic [VAL_W-1:0] value_mask(input logic [LOGQ_W-1:0] lm);
        logic [VAL_W:0] one_hot;
        one_hot = '0;
        if (lm >= LOGQ_W'(VAL_W)) begin
            value_mask = '1;
        end else begin
            one_hot[lm] = 1'b1;
            value_mask = VAL_W'(one_hot - (VAL_W+1)'(1));
        end
    endfunction

endpackage

// ----- src/lsmm_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsmm_ctrl: request sequencer
// Two-state machine: takes one request, then finishes it once the table read
// and the product are ready, holding a read until the output register is free.
// ----------------------------------------------------------------------------
module lsmm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  lsmm_pkg::sts_t sts,
    output lsmm_pkg::cmd_t cmd
);
    import lsmm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   can_commit;

    // A read waits for room in the output register; other requests never wait.
    assign can_commit = (sts.req_type != REQ_READ) || sts.out_free;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (can_commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC: begin
                cmd.commit = can_commit;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/lsmm_datapath.sv -----
// ----------------------------------------------------------------------------
// lsmm_datapath: accumulator table, multiplier and output register
// Holds the 64-entry accumulator memory with per-entry valid bits, forms
// s*b in one registered multiply and writes back or loads the result.
// ----------------------------------------------------------------------------
module lsmm_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lsmm_pkg::cmd_t                    cmd,
    output lsmm_pkg::sts_t                    sts,
    input  logic [lsmm_pkg::LOGQ_W-1:0]       log_modulus,
    input  logic [lsmm_pkg::REQ_W-1:0]        s_tuser,
    input  logic [lsmm_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lsmm_pkg::M_TDATA_W-1:0]    m_tdata
);
    import lsmm_pkg::*;

    // Unpacked request fields.
    logic [IDX_W-1:0] in_row;
    logic [IDX_W-1:0] in_col;
    logic [VAL_W-1:0] in_s;
    logic [VAL_W-1:0] in_b;
    logic [VAL_W-1:0] in_e;
    logic [ADDR_W-1:0] in_addr;

    assign in_row  = s_tdata[2:0];
    assign in_col  = s_tdata[5:3];
    assign in_s    = s_tdata[21:6];
    assign in_b    = s_tdata[37:22];
    assign in_e    = s_tdata[53:38];
    assign in_addr = {in_row, in_col};

    // Held request.
    logic [REQ_W-1:0]  req_reg;
    logic [IDX_W-1:0]  row_reg;
    logic [IDX_W-1:0]  col_reg;
    logic [VAL_W-1:0]  e_reg;
    logic [VAL_W-1:0]  prod_reg;
    logic [VAL_W-1:0]  rd_data_reg;
    logic              rd_valid_reg;

    // Table storage and valid bits.
    logic [VAL_W-1:0]  mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;

    // Output register.
    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic [IDX_W-1:0]  out_row_reg;
    logic [IDX_W-1:0]  out_col_reg;

    logic [VAL_W-1:0]  mask;
    logic [VAL_W-1:0]  entry;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;

    assign mask  = value_mask(log_modulus);
    // An entry never written since reset reads as zero.
    assign entry = rd_valid_reg ? rd_data_reg : '0;

    // Capture the request, the table entry and the low half of the product.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg      <= s_tuser;
            row_reg      <= in_row;
            col_reg      <= in_col;
            e_reg        <= in_e;
            prod_reg     <= VAL_W'(in_s * in_b);
            rd_data_reg  <= mem[in_addr];
            rd_valid_reg <= valid_reg[in_addr];
        end
    end

    // Write-back value for init and multiply-accumulate requests.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {row_reg, col_reg};
        wr_data = e_reg;
        if (cmd.commit) begin
            priority if (req_reg == REQ_INIT) begin
                wr_en   = 1'b1;
                wr_data = e_reg;
            end else if (req_reg == REQ_MAC) begin
                wr_en   = 1'b1;
                wr_data = entry + (prod_reg & mask);
            end else begin
                wr_en = 1'b0;
            end
        end
    end

    // Table write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Valid bits, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Output handshake flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit && (req_reg == REQ_READ)) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (cmd.commit && (req_reg == REQ_READ)) begin
            out_value_reg <= entry & mask;
            out_row_reg   <= row_reg;
            out_col_reg   <= col_reg;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {{(M_TDATA_W - VAL_W - 2*IDX_W){1'b0}},
                           out_col_reg, out_row_reg, out_value_reg};
    assign sts.req_type = req_reg;
    assign sts.out_free = !out_valid_reg || m_tready;

endmodule

// ----- src/lwe_small_matrix_mul_add_mod_2k_top.sv -----
// Sequence: a request is taken in ST_IDLE, where its table entry and product
// are registered, and finished in ST_EXEC, where a read result is loaded into
// the output register. A new request is taken only after the last one is
// finished; a read waits in ST_EXEC while the output is held.
// Reset: aresetn is synchronous, active low; all entries read as zero and
// log_modulus returns to 15. No clearing pass is needed.
// ----------------------------------------------------------------------------
// lwe_small_matrix_mul_add_mod_2k_top: small matrix multiply-add modulo 2^logq
// Accumulates s*b (+e) into an 8x8 table and returns entries masked to
// log_modulus bits, with an APB register for log_modulus.
// ----------------------------------------------------------------------------
module lwe_small_matrix_mul_add_mod_2k_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsmm_pkg::PADDR_W-1:0]    paddr,
    input  logic [lsmm_pkg::PDATA_W-1:0]    pwdata,
    output logic [lsmm_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    // Request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lsmm_pkg::S_TDATA_W-1:0]  s_tdata,  // row_index, col_index, s_value,
                                                      // b_value, e_value, zero pad
    input  logic [lsmm_pkg::REQ_W-1:0]      s_tuser,  // req_type
    // Result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lsmm_pkg::M_TDATA_W-1:0]  m_tdata   // result_value, result_row,
                                                      // result_col, zero pad
);
    import lsmm_pkg::*;

    logic [LOGQ_W-1:0] log_modulus_reg;
    logic              reg_sel;
    cmd_t              cmd;
    sts_t              sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_LOG_MODULUS);

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_modulus_reg <= LOGQ_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            log_modulus_reg <= pwdata[LOGQ_W-1:0];
        end
    end

    // Read back.
    assign prdata = reg_sel ? PDATA_W'(log_modulus_reg) : '0;

    lsmm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lsmm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .log_modulus (log_modulus_reg),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the small matrix multiply-add block
// Drives init, multiply-accumulate, read and unused requests over the stream
// input. It keeps its own 8x8 accumulator table to predict every read result,
// and checks each result field by field. It also walks log_modulus through
// several settings, the extremes among them, using the APB port.
// ----------------------------------------------------------------------------
module tb_top;
    import lsmm_pkg::*;

    localparam int          CLK_PERIOD  = 10;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 200;
    localparam int          PHASE_ITEMS = 250;
    localparam int          NUM_PHASES  = 7;
    localparam logic [REQ_W-1:0]   REQ_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_LOG_MODULUS = {REG_LOG_MODULUS, 2'b00};

    // One request as the block sees it.
    typedef struct {
        logic [REQ_W-1:0] kind;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] s_val;
        logic [VAL_W-1:0] b_val;
        logic [VAL_W-1:0] e_val;
    } mm_req_t;

    // One read result.
    typedef struct {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } entry_read_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [PDATA_W-1:0]     pwdata   = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;  // row_index, col_index, s_value,
                                            // b_value, e_value, zero pad
    logic [REQ_W-1:0]       s_tuser  = '0;  // req_type
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;        // result_value, result_row,
                                            // result_col, zero pad

    // Predictor state: accumulator table and the current modulus width.
    logic [VAL_W-1:0]       acc_table [DEPTH];
    logic [LOGQ_W-1:0]      logq_setting;
    entry_read_t            expected_reads [$];
    mm_req_t                pending_reqs [$];

    int unsigned            reqs_queued   = 0;
    int unsigned            reqs_accepted = 0;
    int unsigned            cycle_count   = 0;
    int unsigned            error_count   = 0;
    int unsigned            n_init = 0, n_mac = 0, n_read = 0, n_ignored = 0;
    int unsigned            n_checked = 0, n_settings = 1;

    // Handshake flags seen at the last rising edge, used by the drivers.
    logic                   req_taken = 1'b0;
    logic                   res_taken = 1'b0;

    // Sender and receiver pacing.
    mm_req_t                next_req;
    int unsigned            send_gap   = 0;
    bit                     send_burst = 1'b0;
    int unsigned            recv_gap   = 0;
    bit                     recv_burst = 1'b0;
    int unsigned            hold_left  = 0;
    int unsigned            holds_asked = 0;
    int unsigned            holds_done  = 0;

    lwe_small_matrix_mul_add_mod_2k_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Low log_modulus bits; widths of 16 and above keep the whole word.
    function automatic logic [VAL_W-1:0] modulus_mask(input logic [LOGQ_W-1:0] lq);
        logic [VAL_W:0] span;
        span = '0;
        if (lq >= LOGQ_W'(VAL_W)) begin
            return '1;
        end
        span = (VAL_W+1)'(1) << lq;
        return VAL_W'(span - 1'b1);
    endfunction

    // Apply one accepted request to the table and record any read result.
    task automatic accumulate_request(input mm_req_t r);
        logic [VAL_W-1:0] mask;
        logic [31:0]      product;
        int               slot;
        entry_read_t      rd;
        mask = modulus_mask(logq_setting);
        slot = int'(r.row) * NBAR + int'(r.col);
        case (r.kind)
            REQ_INIT: begin
                acc_table[slot] = r.e_val;
                n_init++;
            end
            REQ_MAC: begin
                product = 32'(r.s_val) * 32'(r.b_val);
                acc_table[slot] = acc_table[slot] + (product[VAL_W-1:0] & mask);
                n_mac++;
            end
            REQ_READ: begin
                rd.value = acc_table[slot] & mask;
                rd.row   = r.row;
                rd.col   = r.col;
                expected_reads.push_back(rd);
                n_read++;
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Compare one read result with the oldest expectation.
    task automatic check_entry_read(input logic [M_TDATA_W-1:0] word);
        entry_read_t got, want;
        got.value = word[VAL_W-1:0];
        got.row   = word[VAL_W +: IDX_W];
        got.col   = word[VAL_W+IDX_W +: IDX_W];
        if (expected_reads.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %h row %0d col %0d",
                                      got.value, got.row, got.col));
            return;
        end
        want = expected_reads.pop_front();
        n_checked++;
        if (got.value !== want.value) begin
            report_mismatch($sformatf("entry (%0d,%0d) value %h, expected %h",
                                      want.row, want.col, got.value, want.value));
        end
        if (got.row !== want.row) begin
            report_mismatch($sformatf("result row %0d, expected %0d", got.row, want.row));
        end
        if (got.col !== want.col) begin
            report_mismatch($sformatf("result col %0d, expected %0d", got.col, want.col));
        end
    endtask

    function automatic mm_req_t make_req(input logic [REQ_W-1:0] kind,
                                         input logic [IDX_W-1:0] row,
                                         input logic [IDX_W-1:0] col,
                                         input logic [VAL_W-1:0] s_val,
                                         input logic [VAL_W-1:0] b_val,
                                         input logic [VAL_W-1:0] e_val);
        mm_req_t r;
        r.kind  = kind;
        r.row   = row;
        r.col   = col;
        r.s_val = s_val;
        r.b_val = b_val;
        r.e_val = e_val;
        return r;
    endfunction

    // Values lean toward the extremes now and then.
    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(7))
            0:       return '1;
            1:       return '0;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic mm_req_t random_req();
        return make_req(REQ_W'($urandom_range(3)), IDX_W'($urandom_range(NBAR - 1)),
                        IDX_W'($urandom_range(NBAR - 1)), rand_value(), rand_value(),
                        rand_value());
    endfunction

    task automatic queue_req(input mm_req_t r);
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    // A block of the product s*b (+e): init each entry, accumulate over k,
    // then read every entry back.
    task automatic queue_matrix_job(input int rows, input int cols, input int depth,
                                    input bit add_e);
        logic [VAL_W-1:0] s_mat [NBAR][NBAR];
        logic [VAL_W-1:0] b_mat [NBAR][NBAR];
        int               r0, c0;
        r0 = $urandom_range(NBAR - rows);
        c0 = $urandom_range(NBAR - cols);
        for (int i = 0; i < rows; i++)
            for (int k = 0; k < depth; k++)
                s_mat[i][k] = rand_value();
        for (int k = 0; k < depth; k++)
            for (int j = 0; j < cols; j++)
                b_mat[k][j] = rand_value();
        for (int i = 0; i < rows; i++)
            for (int j = 0; j < cols; j++)
                queue_req(make_req(REQ_INIT, IDX_W'(r0 + i), IDX_W'(c0 + j), rand_value(),
                                   rand_value(), add_e ? rand_value() : '0));
        for (int k = 0; k < depth; k++)
            for (int i = 0; i < rows; i++)
                for (int j = 0; j < cols; j++)
                    queue_req(make_req(REQ_MAC, IDX_W'(r0 + i), IDX_W'(c0 + j),
                                       s_mat[i][k], b_mat[k][j], rand_value()));
        for (int i = 0; i < rows; i++)
            for (int j = 0; j < cols; j++)
                queue_req(make_req(REQ_READ, IDX_W'(r0 + i), IDX_W'(c0 + j), rand_value(),
                                   rand_value(), rand_value()));
    endtask

    // Mostly well-formed matrix jobs, with bursts of arbitrary requests.
    task automatic queue_random_phase(input int unsigned target);
        int unsigned first;
        first = reqs_queued;
        while (reqs_queued - first < target) begin
            if ($urandom_range(4) != 0) begin
                queue_matrix_job($urandom_range(1, 4), $urandom_range(1, 4),
                                 $urandom_range(1, 6), $urandom_range(1));
            end else begin
                repeat ($urandom_range(1, 8)) queue_req(random_req());
            end
        end
    endtask

    // Wait until every request is taken and every result has come, then let
    // the block settle so that no init or accumulate is still in flight.
    task automatic wait_for_drain(input int settle);
        while (reqs_accepted != reqs_queued || expected_reads.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic write_log_modulus(input logic [LOGQ_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_LOG_MODULUS;
        pwdata  <= PDATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [LOGQ_W-1:0] phase_logq(input int p);
        case (p)
            0:       return 5'd16;
            1:       return 5'd1;
            2:       return 5'd0;
            3:       return 5'd17;
            4:       return 5'd31;
            5:       return 5'd8;
            default: return 5'd15;
        endcase
    endfunction

    // Request driver: one request at a time from the pending queue, with a
    // random gap drawn after each accepted request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (req_taken) begin
                if ($urandom_range(15) == 0) send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(4);
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                next_req = pending_reqs.pop_front();
                s_tuser  <= next_req.kind;
                s_tdata  <= {2'b00, next_req.e_val, next_req.b_val, next_req.s_val,
                             next_req.col, next_req.row};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: a random stall after each result, plus a long hold
    // whenever the stimulus asks for one.
    always @(negedge aclk) begin
        if (res_taken) begin
            if ($urandom_range(15) == 0) recv_burst = !recv_burst;
            recv_gap = recv_burst ? 0 : $urandom_range(4);
        end
        if (holds_done < holds_asked) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: check results, track the register, predict each request.
    always @(posedge aclk) begin
        req_taken <= aresetn && s_tvalid && s_tready;
        res_taken <= aresetn && m_tvalid && m_tready;
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) acc_table[i] = '0;
            logq_setting = LOGQ_RESET;
        end else begin
            cycle_count++;
            if (m_tvalid && m_tready) begin
                check_entry_read(m_tdata);
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_LOG_MODULUS) begin
                logq_setting = pwdata[LOGQ_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                reqs_accepted++;
                accumulate_request(make_req(s_tuser, s_tdata[IDX_W-1:0],
                                            s_tdata[IDX_W +: IDX_W],
                                            s_tdata[2*IDX_W +: VAL_W],
                                            s_tdata[2*IDX_W+VAL_W +: VAL_W],
                                            s_tdata[2*IDX_W+2*VAL_W +: VAL_W]));
            end
        end
    end

    // Watchdog.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles", cycle_count);
        $display("FAILED: results differ");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset width of 15 bits.
        queue_req(make_req(REQ_READ,   3'd0, 3'd0, 16'h0000, 16'h0000, 16'h0000));
        queue_req(make_req(REQ_READ,   3'd7, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // Init ignores s and b; the read masks the top bit away.
        queue_req(make_req(REQ_INIT,   3'd0, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_req(make_req(REQ_READ,   3'd0, 3'd0, 16'h0000, 16'h0000, 16'h0000));
        // Largest product; e is ignored on accumulate.
        queue_req(make_req(REQ_INIT,   3'd7, 3'd7, 16'h0000, 16'h0000, 16'h0000));
        queue_req(make_req(REQ_MAC,    3'd7, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_req(make_req(REQ_READ,   3'd7, 3'd7, 16'h0000, 16'h0000, 16'h0000));
        // The 16-bit accumulator wraps.
        queue_req(make_req(REQ_MAC,    3'd0, 3'd0, 16'hFFFF, 16'h0001, 16'h0000));
        queue_req(make_req(REQ_READ,   3'd0, 3'd0, 16'h0000, 16'h0000, 16'h0000));
        // The unused request code changes nothing and returns nothing.
        queue_req(make_req(REQ_UNUSED, 3'd0, 3'd0, 16'hFFFF, 16'hFFFF, 16'h5555));
        queue_req(make_req(REQ_READ,   3'd0, 3'd0, 16'h0000, 16'h0000, 16'h0000));
        // Zero factor, and a product whose low 16 bits are all zero.
        queue_req(make_req(REQ_INIT,   3'd3, 3'd5, 16'h0000, 16'h0000, 16'h1234));
        queue_req(make_req(REQ_MAC,    3'd3, 3'd5, 16'h0000, 16'hFFFF, 16'h0000));
        queue_req(make_req(REQ_MAC,    3'd3, 3'd5, 16'h8000, 16'h0002, 16'h0000));
        queue_req(make_req(REQ_READ,   3'd3, 3'd5, 16'h0000, 16'h0000, 16'h0000));
        // Transposed index and back-to-back reads.
        queue_req(make_req(REQ_INIT,   3'd5, 3'd3, 16'h0000, 16'h0000, 16'hA5A5));
        queue_req(make_req(REQ_READ,   3'd5, 3'd3, 16'h0000, 16'h0000, 16'h0000));
        queue_req(make_req(REQ_READ,   3'd3, 3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_req(make_req(REQ_READ,   3'd7, 3'd0, 16'h0000, 16'h0000, 16'h0000));
        wait_for_drain(4);

        // Random phases, each under its own modulus width.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_log_modulus(phase_logq(p));
            if (p == 0) begin
                // Hold the output while reads pile up at the input.
                holds_asked++;
                repeat (40) begin
                    queue_req(make_req(REQ_READ, IDX_W'($urandom_range(NBAR - 1)),
                                       IDX_W'($urandom_range(NBAR - 1)), rand_value(),
                                       rand_value(), rand_value()));
                end
            end
            queue_random_phase(PHASE_ITEMS);
            wait_for_drain(4);
        end

        wait_for_drain(10);
        if (expected_reads.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_reads.size()));
        end

        $display("Run covered %0d init, %0d multiply-accumulate, %0d read and %0d unused",
                 n_init, n_mac, n_read, n_ignored);
        $display("requests over %0d modulus widths; %0d results checked, %0d errors.",
                 n_settings, n_checked, error_count);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
